### hw/rtl/tsr_pkg.sv
`timescale 1ns / 1ps
package tsr_pkg;

  // build-time defaults
  localparam int NUM_SLOTS_DEF = 5;
  localparam int FRAC_BITS_DEF = 16;

  // field widths
  localparam int VAL_W     = 48;
  localparam int CODE_W    = 24;
  localparam int CFG_W     = 40;
  localparam int CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_C    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SERIES    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FULLSCALE = 3'd4;

  // configuration reset values
  localparam logic [39:0] COEF_A_RST    = 40'd64929040000;
  localparam logic [39:0] COEF_B_RST    = 40'd66699960000;
  localparam logic [39:0] COEF_C_RST    = 40'd35568310;
  localparam logic [19:0] SERIES_RST    = 20'd9710;
  localparam logic [23:0] FULLSCALE_RST = 24'd16777215;

  // request and reply codes
  localparam logic       OP_SAMPLE    = 1'b0;
  localparam logic       OP_COMMAND   = 1'b1;
  localparam logic       REPLY_SAMPLE = 1'b0;
  localparam logic       REPLY_READ   = 1'b1;
  localparam logic [7:0] CMD_READ     = 8'h55;
  localparam logic [1:0] CHAN_INTERNAL = 2'd2;

  // ln(2) in Q.30
  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  // largest slot value
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  typedef struct packed {
    logic              operation;
    logic [CODE_W-1:0] adc_code;
    logic [7:0]        command;
    logic [7:0]        slot_request;
  } tsr_in_t;

  typedef struct packed {
    logic                    reply_kind;
    logic [1:0]              next_channel;
    logic signed [VAL_W-1:0] value;
    logic                    conversion_error;
  } tsr_out_t;

endpackage

### hw/rtl/thermistor_scan_and_readout_core.sv
`timescale 1ns / 1ps
// Round-robin thermistor scanner with host read-back. A sample request for
// the internal-sensor slot, a sample with a bad code and a host read each
// go from idle through S_EMIT to the output register. A thermistor sample
// passes S_NUM, then S_NORM and S_LOG twice, S_LM, S_L2, S_L3, S_TB, S_TC,
// S_DIV and S_EMIT: every product goes through one shared 48x16 multiplier
// in three passes (28 squarings per logarithm dominate), the reciprocal
// runs on a restoring divider at one quotient bit per cycle, and the divide
// by five takes seven dividend bits per cycle through a small reciprocal
// multiply. in_ready is high only while the sequencer is idle; a finished
// result waits in the output register without blocking the next request.
module thermistor_scan_and_readout_core #(
  parameter int NUM_SLOTS = tsr_pkg::NUM_SLOTS_DEF,
  parameter int FRAC_BITS = tsr_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tsr_pkg::tsr_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tsr_pkg::tsr_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [tsr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tsr_pkg::CFG_W-1:0]        cfg_wdata
);
  import tsr_pkg::*;

  localparam int IDXW = $clog2(NUM_SLOTS);
  localparam logic [IDXW-1:0] LAST = IDXW'(NUM_SLOTS - 1);
  localparam logic [7:0] LAST8 = 8'(NUM_SLOTS - 1);
  localparam logic [6:0] RECIP_STEPS = 7'(48 + FRAC_BITS);
  localparam logic [6:0] DIV5_STEPS = 7'd9;
  localparam logic [63:0] K_FIX = ((64'd27315 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [57:0] OFFS32 = 58'd32 << FRAC_BITS;
  localparam logic [52:0] T_CAP = 53'd1 << 52;

  typedef enum logic [3:0] {
    S_IDLE, S_NUM, S_NORM, S_LOG, S_LM, S_L2, S_L3, S_TB, S_TC, S_DIV, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic [IDXW-1:0] cur_r, cur_nxt;
  logic [VAL_W-1:0] slot_r [NUM_SLOTS];
  logic [39:0] coef_a_r, coef_b_r, coef_c_r;
  logic [19:0] series_r;
  logic [23:0] fs_r;

  logic [47:0] mul_a_r, mul_a_nxt, mul_b_r, mul_b_nxt;
  logic [95:0] acc_r, acc_nxt;
  logic [1:0]  dig_r, dig_nxt;
  logic [63:0] norm_r, norm_nxt;
  logic [5:0]  exp_r, exp_nxt;
  logic [2:0]  nstep_r, nstep_nxt;
  logic        which_r, which_nxt;
  logic [27:0] frac_r, frac_nxt;
  logic [4:0]  it_r, it_nxt;
  logic [33:0] l2n_r, l2n_nxt;
  logic [23:0] den_r, den_nxt;
  logic [29:0] lm_r, lm_nxt;
  logic [35:0] l2m_r, l2m_nxt;
  logic [41:0] l3m_r, l3m_nxt;
  logic [45:0] tb_r, tb_nxt;
  logic [60:0] rem_r, rem_nxt, divd_r, divd_nxt;
  logic [63:0] dvd_r, dvd_nxt, q_r, q_nxt;
  logic        sat_r, sat_nxt, recip_r, recip_nxt, neg_r, neg_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  tsr_out_t    pend_r, pend_nxt, out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  // shared multiplier: one 16-bit digit of b per cycle, top digit first
  logic [63:0] mul_prod;
  logic [95:0] acc_c;
  logic        mul_last;
  assign mul_prod = mul_a_r * mul_b_r[47:32];
  assign acc_c    = {acc_r[79:0], 16'd0} + {32'd0, mul_prod};
  assign mul_last = (dig_r == 2'd2);

  // normalizer step: shift by 32, 16, 8, 4, 2, 1
  logic [6:0]  nshift;
  logic [63:0] norm_hi;
  assign nshift  = 7'd32 >> nstep_r;
  assign norm_hi = norm_r >> (7'd64 - nshift);

  // restoring divider step
  logic [61:0] rem_sh;
  logic        q_bit;
  assign rem_sh = {rem_r, dvd_r[63]};
  assign q_bit  = (rem_sh >= {1'b0, divd_r});

  // divide-by-five step: remainder and seven dividend bits, digit by x*205 >> 10
  logic [9:0]  d5_v, d5_x;
  logic [16:0] d5_p;
  logic [6:0]  d5_q;
  logic [2:0]  d5_r;
  assign d5_v = {rem_r[2:0], dvd_r[63:57]};
  assign d5_p = {7'd0, d5_v} * 17'd205;
  assign d5_q = d5_p[16:10];
  assign d5_x = d5_v - {1'b0, d5_q, 2'b00} - {3'd0, d5_q};
  assign d5_r = d5_x[2:0];

  function automatic logic [1:0] chan_of(input logic [IDXW-1:0] s);
    chan_of = (s == LAST) ? CHAN_INTERNAL : {1'b0, s[0]};
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  logic             fin_go, fin_err;
  logic [VAL_W-1:0] fin_val;
  logic [48:0]      raw49;
  logic [7:0]       req_c;
  logic [IDXW-1:0]  cur_adv;
  logic [63:0]      sq;
  logic             sq_bit;
  logic [31:0]      m_new;
  logic [33:0]      l2d, mag;
  logic [57:0]      tc;
  logic signed [60:0] dsum;
  logic [52:0]      t_val;
  logic signed [57:0] xk, x9, fq;
  logic [63:0]      mag9;

  always_comb begin
    state_nxt = state_r; cur_nxt = cur_r;
    mul_a_nxt = mul_a_r; mul_b_nxt = mul_b_r; acc_nxt = acc_r; dig_nxt = dig_r;
    norm_nxt = norm_r; exp_nxt = exp_r; nstep_nxt = nstep_r; which_nxt = which_r;
    frac_nxt = frac_r; it_nxt = it_r; l2n_nxt = l2n_r; den_nxt = den_r;
    lm_nxt = lm_r; l2m_nxt = l2m_r; l3m_nxt = l3m_r; tb_nxt = tb_r;
    rem_nxt = rem_r; divd_nxt = divd_r; dvd_nxt = dvd_r; q_nxt = q_r;
    sat_nxt = sat_r; recip_nxt = recip_r; neg_nxt = neg_r; cnt_nxt = cnt_r;
    pend_nxt = pend_r; out_nxt = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    fin_go = 1'b0; fin_err = 1'b0; fin_val = VAL_MAX;
    raw49 = 49'(in_data.adc_code) << FRAC_BITS;
    req_c = (in_data.slot_request > LAST8) ? LAST8 : in_data.slot_request;
    sq = acc_c[63:0];
    sq_bit = sq[63];
    m_new = sq_bit ? sq[63:32] : sq[62:31];
    l2d = {exp_r, frac_r[26:0], sq_bit};
    mag = (l2n_r < l2d) ? (l2d - l2n_r) : (l2n_r - l2d);
    tc = acc_c[81:24];
    dsum = $signed({21'd0, coef_a_r});
    if (neg_r) begin
      dsum = dsum - $signed({15'd0, tb_r}) - $signed({3'd0, tc});
    end else begin
      dsum = dsum + $signed({15'd0, tb_r}) + $signed({3'd0, tc});
    end
    t_val = T_CAP;
    xk = '0; x9 = '0; mag9 = '0; fq = '0;

    // multiplier passes run in every state that uses it
    if (state_r == S_NUM || state_r == S_LOG || state_r == S_LM || state_r == S_L2 ||
        state_r == S_L3 || state_r == S_TB || state_r == S_TC) begin
      acc_nxt   = acc_c;
      mul_b_nxt = mul_b_r << 16;
      dig_nxt   = dig_r + 2'd1;
      if (mul_last) begin
        acc_nxt = '0;
        dig_nxt = '0;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.operation == OP_SAMPLE) begin
            if (cur_r == LAST) begin
              fin_go  = 1'b1;
              fin_val = (raw49[48:47] != 2'd0) ? VAL_MAX : raw49[47:0];
            end else if (in_data.adc_code == '0 || in_data.adc_code >= fs_r ||
                         series_r == '0) begin
              fin_go  = 1'b1;
              fin_err = 1'b1;
            end else begin
              den_nxt   = fs_r - in_data.adc_code;
              mul_a_nxt = {24'd0, in_data.adc_code};
              mul_b_nxt = {28'd0, series_r};
              acc_nxt   = '0;
              dig_nxt   = '0;
              state_nxt = S_NUM;
            end
          end else if (in_data.command == CMD_READ) begin
            pend_nxt.reply_kind       = REPLY_READ;
            pend_nxt.next_channel     = chan_of(cur_r);
            pend_nxt.value            = slot_r[req_c[IDXW-1:0]];
            pend_nxt.conversion_error = 1'b0;
            state_nxt = S_EMIT;
          end
        end
      end
      // resistance numerator product
      S_NUM: begin
        if (mul_last) begin
          norm_nxt  = {20'd0, acc_c[43:0]};
          exp_nxt   = 6'd63;
          nstep_nxt = '0;
          which_nxt = 1'b0;
          state_nxt = S_NORM;
        end
      end
      // find the top bit by halving shifts
      S_NORM: begin
        if (norm_hi == '0) begin
          norm_nxt = norm_r << nshift;
          exp_nxt  = exp_r - nshift[5:0];
        end
        nstep_nxt = nstep_r + 3'd1;
        if (nstep_r == 3'd5) begin
          mul_a_nxt = {16'd0, norm_nxt[63:32]};
          mul_b_nxt = {16'd0, norm_nxt[63:32]};
          acc_nxt   = '0;
          dig_nxt   = '0;
          frac_nxt  = '0;
          it_nxt    = '0;
          state_nxt = S_LOG;
        end
      end
      // fraction bits by repeated squaring
      S_LOG: begin
        if (mul_last) begin
          frac_nxt  = {frac_r[26:0], sq_bit};
          mul_a_nxt = {16'd0, m_new};
          mul_b_nxt = {16'd0, m_new};
          it_nxt    = it_r + 5'd1;
          if (it_r == 5'd27) begin
            if (!which_r) begin
              l2n_nxt   = l2d;
              norm_nxt  = {40'd0, den_r};
              exp_nxt   = 6'd63;
              nstep_nxt = '0;
              which_nxt = 1'b1;
              state_nxt = S_NORM;
            end else begin
              neg_nxt   = (l2n_r < l2d);
              mul_a_nxt = {14'd0, mag};
              mul_b_nxt = {18'd0, LN2_Q30};
              state_nxt = S_LM;
            end
          end
        end
      end
      S_LM: begin
        if (mul_last) begin
          lm_nxt    = acc_c[63:34];
          mul_a_nxt = {18'd0, acc_c[63:34]};
          mul_b_nxt = {18'd0, acc_c[63:34]};
          state_nxt = S_L2;
        end
      end
      S_L2: begin
        if (mul_last) begin
          l2m_nxt   = acc_c[59:24];
          mul_a_nxt = {12'd0, acc_c[59:24]};
          mul_b_nxt = {18'd0, lm_r};
          state_nxt = S_L3;
        end
      end
      S_L3: begin
        if (mul_last) begin
          l3m_nxt   = acc_c[65:24];
          mul_a_nxt = {8'd0, coef_b_r};
          mul_b_nxt = {18'd0, lm_r};
          state_nxt = S_TB;
        end
      end
      S_TB: begin
        if (mul_last) begin
          tb_nxt    = acc_c[69:24];
          mul_a_nxt = {8'd0, coef_c_r};
          mul_b_nxt = {6'd0, l3m_r};
          state_nxt = S_TC;
        end
      end
      // denominator sum; an error if it is not positive, else start the reciprocal
      S_TC: begin
        if (mul_last) begin
          if (dsum <= 0) begin
            fin_go  = 1'b1;
            fin_err = 1'b1;
          end else begin
            rem_nxt   = 61'd1;
            dvd_nxt   = '0;
            divd_nxt  = dsum;
            q_nxt     = '0;
            sat_nxt   = 1'b0;
            recip_nxt = 1'b1;
            cnt_nxt   = RECIP_STEPS;
            state_nxt = S_DIV;
          end
        end
      end
      // reciprocal one quotient bit per cycle, divide by five seven bits per cycle
      S_DIV: begin
        if (recip_r) begin
          rem_nxt = q_bit ? 61'(rem_sh - {1'b0, divd_r}) : rem_sh[60:0];
          dvd_nxt = dvd_r << 1;
          q_nxt   = {q_r[62:0], q_bit};
          if (q_nxt[52]) begin
            sat_nxt = 1'b1;
          end
        end else begin
          rem_nxt = {58'd0, d5_r};
          dvd_nxt = dvd_r << 7;
          q_nxt   = {q_r[56:0], d5_q};
        end
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          if (recip_r) begin
            t_val     = sat_nxt ? T_CAP : q_nxt[52:0];
            xk        = $signed({5'd0, t_val}) - $signed(K_FIX[57:0]);
            x9        = (xk <<< 3) + xk;
            mag9      = {6'd0, (x9 < 0) ? 58'(-x9) : 58'(x9)};
            neg_nxt   = (x9 < 0);
            rem_nxt   = '0;
            dvd_nxt   = mag9 << 1;
            divd_nxt  = 61'd5;
            q_nxt     = '0;
            recip_nxt = 1'b0;
            cnt_nxt   = DIV5_STEPS;
          end else begin
            fq = neg_r ? -$signed(q_nxt[57:0]) : $signed(q_nxt[57:0]);
            fq = fq + $signed(OFFS32);
            fin_go  = 1'b1;
            fin_val = (fq > $signed({10'd0, VAL_MAX})) ? VAL_MAX : fq[47:0];
          end
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // store a finished sample and advance the scan
    cur_adv = (cur_r == LAST) ? '0 : cur_r + 1'b1;
    if (fin_go) begin
      cur_nxt = cur_adv;
      pend_nxt.reply_kind       = REPLY_SAMPLE;
      pend_nxt.next_channel     = chan_of(cur_adv);
      pend_nxt.value            = fin_val;
      pend_nxt.conversion_error = fin_err;
      state_nxt = S_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
      coef_a_r    <= COEF_A_RST;
      coef_b_r    <= COEF_B_RST;
      coef_c_r    <= COEF_C_RST;
      series_r    <= SERIES_RST;
      fs_r        <= FULLSCALE_RST;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
      if (fin_go) begin
        slot_r[cur_r] <= fin_val;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_COEF_A:    coef_a_r <= cfg_wdata;
          REG_COEF_B:    coef_b_r <= cfg_wdata;
          REG_COEF_C:    coef_c_r <= cfg_wdata;
          REG_SERIES:    series_r <= cfg_wdata[19:0];
          REG_FULLSCALE: fs_r     <= cfg_wdata[23:0];
          default: ;
        endcase
      end
    end
    mul_a_r <= mul_a_nxt; mul_b_r <= mul_b_nxt; acc_r <= acc_nxt; dig_r <= dig_nxt;
    norm_r <= norm_nxt; exp_r <= exp_nxt; nstep_r <= nstep_nxt; which_r <= which_nxt;
    frac_r <= frac_nxt; it_r <= it_nxt; l2n_r <= l2n_nxt; den_r <= den_nxt;
    lm_r <= lm_nxt; l2m_r <= l2m_nxt; l3m_r <= l3m_nxt; tb_r <= tb_nxt;
    rem_r <= rem_nxt; divd_r <= divd_nxt; dvd_r <= dvd_nxt; q_r <= q_nxt;
    sat_r <= sat_nxt; recip_r <= recip_nxt; neg_r <= neg_nxt; cnt_r <= cnt_nxt;
    pend_r <= pend_nxt; out_r <= out_nxt;
  end

`ifndef NO_ASSERTIONS
  // scan index never leaves the slot range
  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= LAST) else $error("slot index out of range");

  // log mantissa stays normalized while squaring
  a_log_norm: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOG |-> mul_a_r[31] && mul_a_r[47:32] == '0)
    else $error("log mantissa not normalized");

  // a sample request always leaves the sequencer busy in the cycle after it is accepted
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.operation == OP_SAMPLE |=> !in_ready)
    else $error("ready right after sample request");

  // an error reply carries the saturated value
  a_err_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.conversion_error |->
      out_data.value == VAL_MAX && out_data.reply_kind == REPLY_SAMPLE)
    else $error("bad error reply");
`endif

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import tsr_pkg::*;

  localparam int NSLOT = NUM_SLOTS_DEF;
  localparam int FRAC  = FRAC_BITS_DEF;
  localparam longint VMAX = 64'h7FFF_FFFF_FFFF;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  tsr_in_t in_data;
  logic out_valid;
  logic out_ready;
  tsr_out_t out_data;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  thermistor_scan_and_readout_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // shadow of the block's state and registers
  longint slot_mem [NSLOT];
  int unsigned cur_slot;
  longint unsigned sh_coef_a, sh_coef_b, sh_coef_c, sh_series, sh_fullscale;

  tsr_out_t pending_replies[$];
  int fail_cnt = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;

  // 64x64 product shifted right, saturating at all ones
  function automatic longint unsigned mul_shift(input longint unsigned a,
                                                input longint unsigned b,
                                                input int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    if (p[127:64] != 64'd0) return 64'hFFFF_FFFF_FFFF_FFFF;
    return p[63:0];
  endfunction

  // log2 in Q.28 by repeated squaring
  function automatic longint unsigned log2_fix(input longint unsigned x);
    int e;
    longint unsigned m, p, frac;
    e = 0;
    frac = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    m = (e >= 31) ? (x >> (e - 31)) : (x << (31 - e));
    for (int i = 0; i < 28; i++) begin
      p = m * m;
      frac = frac << 1;
      if (p[63]) begin
        frac = frac | 1;
        m = p >> 32;
      end else begin
        m = p >> 31;
      end
    end
    return (longint'(e) << 28) | frac;
  endfunction

  // code to fahrenheit; returns 0 when the sample cannot be converted
  function automatic bit code_to_fahrenheit(input longint unsigned code,
                                            output longint f);
    longint unsigned l2n, l2d, mag, lm, l2m, l3m, tb_term, tc_term, q, rem;
    longint d, t, k;
    bit neg, sat;
    f = VMAX;
    sat = 0;
    if (code == 0 || code >= sh_fullscale || sh_series == 0) return 0;
    l2n = log2_fix(sh_series * code);
    l2d = log2_fix(sh_fullscale - code);
    neg = l2n < l2d;
    mag = neg ? (l2d - l2n) : (l2n - l2d);
    lm = (mag * 64'd744261118) >> 34;
    l2m = mul_shift(lm, lm, 24);
    l3m = mul_shift(l2m, lm, 24);
    tb_term = mul_shift(sh_coef_b, lm, 24);
    tc_term = mul_shift(sh_coef_c, l3m, 24);
    d = longint'(sh_coef_a);
    if (neg) d = d - longint'(tb_term) - longint'(tc_term);
    else d = d + longint'(tb_term) + longint'(tc_term);
    if (d <= 0) return 0;
    q = 0;
    rem = 1;
    for (int i = 0; i < 48 + FRAC; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= longint'(d)) begin
        rem = rem - d;
        q = q | 1;
      end
      if (q >= (64'd1 << 52)) begin
        sat = 1;
        break;
      end
    end
    t = sat ? (longint'(1) << 52) : longint'(q);
    k = ((longint'(27315) << FRAC) + 50) / 100;
    f = ((t - k) * 9) / 5 + (longint'(32) << FRAC);
    if (f > VMAX) f = VMAX;
    return 1;
  endfunction

  function automatic logic [1:0] chan_of(input int unsigned s);
    return (s == NSLOT - 1) ? CHAN_INTERNAL : 2'(s & 1);
  endfunction

  // expected reply for one accepted request, updates the shadow state
  function automatic void predict_reply(input tsr_in_t r);
    tsr_out_t o;
    longint v;
    longint unsigned raw;
    int unsigned req;
    o = '0;
    if (r.operation == OP_SAMPLE) begin
      o.conversion_error = 1'b0;
      if (cur_slot == NSLOT - 1) begin
        raw = longint'(r.adc_code) << FRAC;
        v = (raw > VMAX) ? VMAX : longint'(raw);
      end else if (!code_to_fahrenheit(r.adc_code, v)) begin
        v = VMAX;
        o.conversion_error = 1'b1;
      end
      slot_mem[cur_slot] = v;
      cur_slot = (cur_slot + 1 >= NSLOT) ? 0 : cur_slot + 1;
      o.reply_kind = REPLY_SAMPLE;
      o.next_channel = chan_of(cur_slot);
      o.value = v[VAL_W-1:0];
      pending_replies.push_back(o);
    end else if (r.command == CMD_READ) begin
      req = (r.slot_request >= NSLOT) ? NSLOT - 1 : r.slot_request;
      o.reply_kind = REPLY_READ;
      o.next_channel = chan_of(cur_slot);
      o.value = slot_mem[req][VAL_W-1:0];
      pending_replies.push_back(o);
    end
  endfunction

  // reply checker with random stalls
  always @(posedge clk) begin
    tsr_out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_replies.size() == 0) begin
        $error("unexpected reply %h", out_data);
        fail_cnt++;
      end else begin
        exp_r = pending_replies.pop_front();
        if (out_data.reply_kind !== exp_r.reply_kind) begin
          $error("reply_kind exp %0d got %0d", exp_r.reply_kind, out_data.reply_kind);
          fail_cnt++;
        end
        if (out_data.next_channel !== exp_r.next_channel) begin
          $error("next_channel exp %0d got %0d", exp_r.next_channel,
                 out_data.next_channel);
          fail_cnt++;
        end
        if (out_data.value !== exp_r.value) begin
          $error("value exp %h got %h", exp_r.value, out_data.value);
          fail_cnt++;
        end
        if (out_data.conversion_error !== exp_r.conversion_error) begin
          $error("conversion_error exp %0d got %0d", exp_r.conversion_error,
                 out_data.conversion_error);
          fail_cnt++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // send one request, with a random gap before it
  task automatic send_req(input tsr_in_t r);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
    predict_reply(r);
  endtask

  task automatic send_sample(input logic [CODE_W-1:0] code);
    tsr_in_t r;
    r = '0;
    r.operation = OP_SAMPLE;
    r.adc_code = code;
    r.command = 8'($urandom);
    r.slot_request = 8'($urandom);
    send_req(r);
  endtask

  task automatic send_cmd(input logic [7:0] cmd, input logic [7:0] req);
    tsr_in_t r;
    r = '0;
    r.operation = OP_COMMAND;
    r.adc_code = CODE_W'($urandom);
    r.command = cmd;
    r.slot_request = req;
    send_req(r);
  endtask

  // drain every reply, then let a dropped command settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_COEF_A:    sh_coef_a = val & 64'hFF_FFFF_FFFF;
      REG_COEF_B:    sh_coef_b = val & 64'hFF_FFFF_FFFF;
      REG_COEF_C:    sh_coef_c = val & 64'hFF_FFFF_FFFF;
      REG_SERIES:    sh_series = val & 64'hF_FFFF;
      REG_FULLSCALE: sh_fullscale = val & 64'hFF_FFFF;
      default: ;
    endcase
  endtask

  task automatic load_cfg(input longint unsigned a, input longint unsigned b,
                          input longint unsigned c, input longint unsigned rs,
                          input longint unsigned fs);
    drain();
    write_reg(REG_COEF_A, a);
    write_reg(REG_COEF_B, b);
    write_reg(REG_COEF_C, c);
    write_reg(REG_SERIES, rs);
    write_reg(REG_FULLSCALE, fs);
  endtask

  // slots read back as zero after reset, clamping included
  task automatic test_reset_readback();
    for (int i = 0; i < NSLOT; i++) send_cmd(CMD_READ, 8'(i));
    send_cmd(CMD_READ, 8'd255);
  endtask

  // edge codes, raw slot, ignored commands, clamped reads
  task automatic test_directed();
    send_sample(24'd0);
    send_sample(24'd1);
    send_sample(24'(sh_fullscale - 1));
    send_sample(24'(sh_fullscale));
    send_sample(24'hFFFFFF);
    send_sample(24'd8388608);
    send_sample(24'd5000000);
    send_sample(24'd16000000);
    send_sample(24'd12345);
    send_cmd(8'h00, 8'd0);
    send_cmd(8'hAA, 8'd1);
    send_cmd(8'h54, 8'd2);
    send_cmd(8'hFF, 8'd3);
    for (int i = 0; i < NSLOT; i++) send_cmd(CMD_READ, 8'(i));
    send_cmd(CMD_READ, 8'd5);
    send_cmd(CMD_READ, 8'd128);
    send_cmd(CMD_READ, 8'd255);
  endtask

  // random mix of samples and host commands
  task automatic test_random(input int n);
    logic [CODE_W-1:0] code;
    int sel;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1)) begin
        sel = $urandom_range(9);
        case (sel)
          0: code = 0;
          1: code = 24'(sh_fullscale);
          2: code = 24'(sh_fullscale - 1);
          3: code = CODE_W'($urandom);
          default: code = (sh_fullscale > 1) ?
                          24'($urandom_range(sh_fullscale - 1, 1)) : 24'd0;
        endcase
        send_sample(code);
      end else if ($urandom_range(4) != 0) begin
        send_cmd(CMD_READ, $urandom_range(3) ? 8'($urandom_range(7)) : 8'($urandom));
      end else begin
        send_cmd(8'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic set_idle(input int snd, input int rcv);
    snd_idle_pct = snd;
    rcv_stall_pct = rcv;
  endtask

  task automatic test_idle_phases(input int n);
    set_idle(0, 0);   test_random(n);
    set_idle(85, 0);  test_random(n);
    set_idle(0, 85);  test_random(n);
    set_idle(31, 31); test_random(n);
  endtask

  // main sequence
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    for (int i = 0; i < NSLOT; i++) slot_mem[i] = 0;
    cur_slot = 0;
    sh_coef_a = COEF_A_RST;
    sh_coef_b = COEF_B_RST;
    sh_coef_c = COEF_C_RST;
    sh_series = SERIES_RST;
    sh_fullscale = FULLSCALE_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_readback();
    test_directed();
    test_idle_phases(100);

    // extreme registers: all max
    load_cfg(64'hFF_FFFF_FFFF, 64'hFF_FFFF_FFFF, 64'hFF_FFFF_FFFF, 64'hF_FFFF, 64'hFF_FFFF);
    test_directed();
    test_idle_phases(50);

    // zero coefficients, denominator not positive
    load_cfg(0, 0, 0, 1, 1000);
    test_idle_phases(40);

    // small A with large B, negative log drives the denominator below zero
    load_cfg(1000, 64'hFF_FFFF_FFFF, 64'hFF_FFFF, 1, 64'hFF_FFFF);
    test_idle_phases(60);

    // full scale of one, every thermistor sample is bad
    load_cfg(COEF_A_RST, COEF_B_RST, COEF_C_RST, SERIES_RST, 1);
    test_idle_phases(30);

    // small full scale and resistor
    load_cfg(COEF_A_RST, COEF_B_RST, COEF_C_RST, 100, 4095);
    test_idle_phases(60);

    // back to defaults
    load_cfg(COEF_A_RST, COEF_B_RST, COEF_C_RST, SERIES_RST, FULLSCALE_RST);
    test_idle_phases(120);

    drain();
    repeat (50) @(posedge clk);
    if (fail_cnt == 0 && pending_replies.size() == 0) begin
      $display("thermistor_scan_and_readout_core test passed");
    end else begin
      $display("thermistor_scan_and_readout_core test failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #80ms;
    $display("thermistor_scan_and_readout_core test failed");
    $finish;
  end

endmodule
